/* rtl/fmbi_pkg.sv */
// Shared types and constants for the bilinear field map interpolator
`default_nettype none
package fmbi_pkg;
    localparam logic [1:0] REQ_LOAD_RADIAL = 2'd0;
    localparam logic [1:0] REQ_LOAD_AXIAL  = 2'd1;
    localparam logic [1:0] REQ_LOAD_MAP    = 2'd2;
    localparam logic [1:0] REQ_QUERY       = 2'd3;

    localparam logic [1:0] CFG_RADIAL_COUNT = 2'd0;
    localparam logic [1:0] CFG_AXIAL_COUNT  = 2'd1;
    localparam logic [1:0] CFG_RADIAL_LIMIT = 2'd2;
    localparam logic [1:0] CFG_AXIAL_LIMIT  = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MAP_IDX_W  = 14;
    localparam int LOAD_W     = 24;
    localparam int FRAC_W     = 17;   // Q16 fraction, 0..65536

    // unsigned divider request: num <= den, quotient floor(num*65536/den)
    typedef struct packed {
        logic        start;
        logic [16:0] num;
        logic [16:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_rsp;
endpackage
`default_nettype wire

/* rtl/fmbi_div.sv */
// Restoring divider forming a Q16 fraction, one quotient bit a cycle
`default_nettype none
module fmbi_div
    import fmbi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [17:0]       r_rem, n_rem;
    logic [16:0]       r_den;
    logic [FRAC_W-1:0] r_quot, n_quot;
    logic [4:0]        r_cnt;
    logic              r_busy, r_done;
    logic [18:0]       w_trial;

    // shift numerator in zeroes and subtract the denominator where it fits;
    // a zero denominator leaves the quotient at zero
    always_comb begin
        w_trial = {r_rem, 1'b0} - {2'b00, r_den};
        if (!w_trial[18] && r_den != '0) begin
            n_rem  = w_trial[17:0];
            n_quot = {r_quot[FRAC_W-2:0], 1'b1};
        end else begin
            n_rem  = {r_rem[16:0], 1'b0};
            n_quot = {r_quot[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd16;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // quotient starts from num/den, which is 0 or 1 since num <= den
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.den;
            if (i_req.num == i_req.den && i_req.den != '0) begin
                r_rem  <= '0;
                r_quot <= {{(FRAC_W-1){1'b0}}, 1'b1};
            end else begin
                r_rem  <= {1'b0, i_req.num};
                r_quot <= '0;
            end
        end else if (r_busy && r_cnt != 5'd0) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule
`default_nettype wire

/* rtl/field_map_bilinear_interp.sv */
// Top level: grid and map memories with a query sequencer
//
//  channel | dir | signals
//  --------+-----+-------------------------------------------------
//  request | in  | i_valid/o_ready, i_req_type .. i_axial_position
//  result  | out | o_valid/i_ready, o_field_axial, o_status
//  config  | in  | i_cfg_we, i_cfg_index, i_cfg_data
//
// A load or an out-of-range query goes straight to the result. A query scans the
// radial grid one entry a cycle, then the axial grid, runs two divisions on the
// shared divider and four map reads with one multiply-accumulate each.
// One transaction is in flight at a time; a held result stalls new input.
// Synchronous reset clears control only; memories are undefined until loaded.
`default_nettype none
module field_map_bilinear_interp
    import fmbi_pkg::*;
#(
    parameter int MAX_RADIAL_POINTS = 64,
    parameter int MAX_AXIAL_POINTS  = 256,
    parameter int FIELD_WIDTH       = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [MAP_IDX_W-1:0]    i_table_index,
    input  wire logic signed [LOAD_W-1:0] i_load_value,
    input  wire logic signed [15:0]      i_radius,
    input  wire logic signed [16:0]      i_axial_position,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [FIELD_WIDTH-1:0] o_field_axial,
    output logic                         o_status,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int RW = $clog2(MAX_RADIAL_POINTS);
    localparam int AW = $clog2(MAX_AXIAL_POINTS);
    localparam int RCW = RW + 1;
    localparam int ACW = AW + 1;
    localparam int ACC_W = FIELD_WIDTH + 36;

    localparam logic [3:0] S_IDLE = 4'd0, S_RSCAN = 4'd1, S_RPAIR = 4'd2,
        S_ASCAN = 4'd3, S_APAIR = 4'd4, S_RDIV = 4'd5, S_ADIV = 4'd6,
        S_MREAD = 4'd7, S_MACC = 4'd8, S_ROUND = 4'd9, S_OUT = 4'd10,
        S_RWAIT = 4'd11, S_AWAIT = 4'd12;

    // configuration registers
    logic [6:0]  r_radial_count;
    logic [8:0]  r_axial_count;
    logic [14:0] r_radial_limit;
    logic [15:0] r_axial_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radial_count <= 7'd64;
            r_axial_count  <= 9'd256;
            r_radial_limit <= 15'd15360;
            r_axial_limit  <= 16'd25600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIAL_COUNT: r_radial_count <= i_cfg_data[6:0];
                CFG_AXIAL_COUNT:  r_axial_count  <= i_cfg_data[8:0];
                CFG_RADIAL_LIMIT: r_radial_limit <= i_cfg_data[14:0];
                CFG_AXIAL_LIMIT:  r_axial_limit  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamp counts to [2, max]
    logic [RCW-1:0] w_rc;
    logic [ACW-1:0] w_ac;
    always_comb begin
        if (r_radial_count < 7'd2) w_rc = RCW'(2);
        else if ({25'd0, r_radial_count} > 32'(MAX_RADIAL_POINTS))
            w_rc = RCW'(MAX_RADIAL_POINTS);
        else w_rc = RCW'(r_radial_count);
        if (r_axial_count < 9'd2) w_ac = ACW'(2);
        else if ({23'd0, r_axial_count} > 32'(MAX_AXIAL_POINTS))
            w_ac = ACW'(MAX_AXIAL_POINTS);
        else w_ac = ACW'(r_axial_count);
    end

    // memories
    logic [14:0] m_rgrid [MAX_RADIAL_POINTS];
    logic [15:0] m_agrid [MAX_AXIAL_POINTS];
    logic signed [FIELD_WIDTH-1:0] m_map [2**MAP_IDX_W];

    logic [3:0]  r_state;
    logic [14:0] r_s;
    logic [15:0] r_z;
    logic [RCW-1:0] r_k;
    logic [ACW-1:0] r_j;
    logic [RCW-1:0] r_ll;
    logic [ACW-1:0] r_mm;
    logic [15:0] r_glo, r_ghi;
    logic [1:0]  r_corner;
    logic [FRAC_W-1:0] r_t, r_u;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [35:0] r_w;
    logic signed [FIELD_WIDTH-1:0] r_fa;
    logic r_st;
    logic r_busy_div;

    logic [RW-1:0] w_raddr;
    logic [AW-1:0] w_aaddr;
    logic [MAP_IDX_W-1:0] w_maddr;
    logic [14:0] r_rdata;
    logic [15:0] r_adata;
    logic signed [FIELD_WIDTH-1:0] r_mdata;

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && i_req_type == REQ_LOAD_RADIAL
                && {18'd0, i_table_index} < 32'(MAX_RADIAL_POINTS))
            m_rgrid[i_table_index[RW-1:0]] <= i_load_value[14:0];
        r_rdata <= m_rgrid[w_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && i_req_type == REQ_LOAD_AXIAL
                && {18'd0, i_table_index} < 32'(MAX_AXIAL_POINTS))
            m_agrid[i_table_index[AW-1:0]] <= i_load_value[15:0];
        r_adata <= m_agrid[w_aaddr];
    end
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && i_req_type == REQ_LOAD_MAP)
            m_map[i_table_index] <= FIELD_WIDTH'(i_load_value);
        r_mdata <= m_map[w_maddr];
    end

    // read addresses: upper radial entry first, then the lower one
    logic [RCW-1:0] w_lsel;
    logic [ACW-1:0] w_msel;
    always_comb begin
        w_lsel = r_ll + RCW'(r_corner[0]);
        w_msel = r_mm + ACW'(r_corner[1]);
        w_raddr = (r_state == S_RPAIR)
                  ? RW'(r_ll + RCW'(1)) : r_k[RW-1:0];
        w_aaddr = (r_state == S_APAIR || r_state == S_AWAIT)
                  ? AW'(r_mm + ACW'(1)) : r_j[AW-1:0];
        w_maddr = MAP_IDX_W'(({6'd0, w_lsel} << 8) + {6'd0, w_msel});
    end

    // fraction divider shared by both axes
    t_div_req w_dreq;
    t_div_rsp w_drsp;
    fmbi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic [16:0] w_den, w_num;
    logic [15:0] w_coord;
    always_comb begin
        w_coord = (r_state == S_RDIV) ? {1'b0, r_s} : r_z;
        w_den = {1'b0, r_ghi} - {1'b0, r_glo};
        w_num = {1'b0, w_coord} - {1'b0, r_glo};
        if (r_ghi <= r_glo) begin
            w_den = '0;
            w_num = '0;
        end else if (w_coord < r_glo) w_num = '0;
        else if (w_coord > r_ghi) w_num = w_den;
        w_dreq.start = (r_state == S_RDIV || r_state == S_ADIV) && !r_busy_div;
        w_dreq.num = w_num;
        w_dreq.den = w_den;
    end

    // corner weight
    logic [FRAC_W-1:0] w_wt, w_wu;
    always_comb begin
        w_wt = r_corner[0] ? r_t : (FRAC_W'(65536) - r_t);
        w_wu = r_corner[1] ? r_u : (FRAC_W'(65536) - r_u);
    end

    logic w_oor;
    logic signed [17:0] w_zneg;
    always_comb begin
        w_zneg = -$signed({1'b0, i_axial_position});
        w_oor = i_radius < 0 || $signed({1'b0, i_radius}) > $signed({2'b0, r_radial_limit})
            || $signed(i_axial_position) > $signed({1'b0, r_axial_limit})
            || $signed(i_axial_position) < -$signed({1'b0, r_axial_limit});
    end

    logic [ACC_W-1:0] w_biased;
    assign w_biased = ACC_W'(r_acc) + (ACC_W'(1) << 31);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_field_axial = r_fa;
    assign o_status = r_st;

    // query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy_div <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_fa <= '0;
                    r_st <= 1'b0;
                    r_k <= '0;
                    r_j <= '0;
                    r_s <= i_radius[14:0];
                    r_z <= i_axial_position[16] ? w_zneg[15:0] : i_axial_position[15:0];
                    if (i_req_type == REQ_QUERY && !w_oor) r_state <= S_RSCAN;
                    else begin
                        r_st <= (i_req_type == REQ_QUERY);
                        r_state <= S_OUT;
                    end
                end
                // data for r_k-1 arrives; scan until entry >= coordinate
                S_RSCAN: begin
                    if (r_k != '0 && r_rdata >= r_s) begin
                        r_ll <= (r_rdata == r_s) ? r_k - RCW'(1) : r_k - RCW'(2);
                        if (r_rdata != r_s && r_k == RCW'(1)) r_ll <= '0;
                        if (r_rdata == r_s && r_k - RCW'(1) > w_rc - RCW'(2))
                            r_ll <= w_rc - RCW'(2);
                        r_state <= S_RPAIR;
                    end else if (r_k == w_rc) begin
                        r_ll <= w_rc - RCW'(2);
                        r_state <= S_RPAIR;
                    end else r_k <= r_k + RCW'(1);
                end
                S_RPAIR: begin
                    r_k <= r_ll;
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_ghi <= {1'b0, r_rdata};
                    r_state <= S_ASCAN;
                end
                S_ASCAN: begin
                    if (r_k == r_ll) begin
                        r_glo <= {1'b0, r_rdata};
                        r_k <= r_k + RCW'(1);
                    end
                    if (r_j != '0 && r_adata >= r_z) begin
                        r_mm <= (r_adata == r_z) ? r_j - ACW'(1) : r_j - ACW'(2);
                        if (r_adata != r_z && r_j == ACW'(1)) r_mm <= '0;
                        if (r_adata == r_z && r_j - ACW'(1) > w_ac - ACW'(2))
                            r_mm <= w_ac - ACW'(2);
                        r_state <= S_APAIR;
                    end else if (r_j == w_ac) begin
                        r_mm <= w_ac - ACW'(2);
                        r_state <= S_APAIR;
                    end else r_j <= r_j + ACW'(1);
                end
                S_APAIR: begin
                    r_j <= r_mm;
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    if (!r_busy_div) begin
                        r_busy_div <= 1'b1;
                        r_ghi <= r_adata;   // axial upper, parked
                    end else if (w_drsp.done) begin
                        r_t <= w_drsp.quot;
                        r_busy_div <= 1'b0;
                        r_glo <= r_adata;
                        r_state <= S_ADIV;
                    end
                end
                S_ADIV: begin
                    if (!r_busy_div) r_busy_div <= 1'b1;
                    else if (w_drsp.done) begin
                        r_u <= w_drsp.quot;
                        r_busy_div <= 1'b0;
                        r_corner <= 2'd0;
                        r_acc <= '0;
                        r_state <= S_MREAD;
                    end
                end
                S_MREAD: begin
                    r_w <= $signed({1'b0, w_wt}) * $signed({1'b0, w_wu});
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    r_acc <= r_acc + ACC_W'(r_w) * ACC_W'(r_mdata);
                    r_corner <= r_corner + 2'd1;
                    r_state <= (r_corner == 2'd3) ? S_ROUND : S_MREAD;
                end
                S_ROUND: begin
                    r_fa <= FIELD_WIDTH'(w_biased >> 32);
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the bilinear field map interpolator
`timescale 1ns / 1ps
module tb;
    import fmbi_pkg::*;

    localparam int RPTS = 64;
    localparam int APTS = 256;
    localparam int FW   = 24;

    typedef struct packed {
        logic signed [FW-1:0] field;
        logic                 status;
    } t_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_req_type = REQ_QUERY;
    logic [MAP_IDX_W-1:0]   i_table_index = '0;
    logic signed [LOAD_W-1:0] i_load_value = '0;
    logic signed [15:0]     i_radius = '0;
    logic signed [16:0]     i_axial_position = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [FW-1:0]   o_field_axial;
    logic                   o_status;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_RADIAL_COUNT;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    field_map_bilinear_interp uut (.*);

    always #4 i_clk = ~i_clk;

    // local copy of block state and registers
    logic [14:0]          radial_pts [RPTS];
    logic [15:0]          axial_pts  [APTS];
    logic signed [FW-1:0] field_tbl  [16384];
    bit                   field_set  [16384];
    int unsigned          reg_rcount = 64, reg_acount = 256;
    int unsigned          reg_rlimit = 15360, reg_alimit = 25600;

    t_result     pending_results [$];
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    int unsigned hold_cycles = 0;

    // ---------------------------------------------------------------- predictor
    function automatic int unsigned clamp_pts(int unsigned c, int unsigned maxc);
        if (c < 2) return 2;
        if (c > maxc) return maxc;
        return c;
    endfunction

    function automatic longint frac_q16(longint x, longint lo, longint hi);
        longint den, num;
        den = hi - lo;
        num = x - lo;
        if (den <= 0) return 0;
        if (num < 0) num = 0;
        if (num > den) num = den;
        return (num * 65536) / den;
    endfunction

    // range check, mirror and cell search for one query
    function automatic void locate_cell(input longint s, input longint z,
                                        output bit in_range, output int ll, output int mm);
        int unsigned rc, ac, k;
        in_range = !(z < -longint'(reg_alimit) || z > longint'(reg_alimit) ||
                     s < 0 || s > longint'(reg_rlimit));
        if (z < 0) z = -z;
        rc = clamp_pts(reg_rcount, RPTS);
        ac = clamp_pts(reg_acount, APTS);
        k = rc;
        for (int i = rc - 1; i >= 0; i--) if (longint'(radial_pts[i]) >= s) k = i;
        ll = (k < rc && longint'(radial_pts[k]) == s) ? k : int'(k) - 1;
        if (ll < 0) ll = 0;
        if (ll > int'(rc) - 2) ll = rc - 2;
        k = ac;
        for (int i = ac - 1; i >= 0; i--) if (longint'(axial_pts[i]) >= z) k = i;
        mm = (k < ac && longint'(axial_pts[k]) == z) ? k : int'(k) - 1;
        if (mm < 0) mm = 0;
        if (mm > int'(ac) - 2) mm = ac - 2;
    endfunction

    function automatic t_result interp_field(longint s, longint z);
        t_result res;
        bit      ok;
        int      ll, mm;
        longint  t, u, acc;
        res = '0;
        locate_cell(s, z, ok, ll, mm);
        if (!ok) begin
            res.status = 1'b1;
            return res;
        end
        if (z < 0) z = -z;
        t = frac_q16(s, radial_pts[ll], radial_pts[ll + 1]);
        u = frac_q16(z, axial_pts[mm], axial_pts[mm + 1]);
        acc = (65536 - t) * (65536 - u) * longint'(field_tbl[ll * 256 + mm])
            + t * (65536 - u) * longint'(field_tbl[(ll + 1) * 256 + mm])
            + (65536 - t) * u * longint'(field_tbl[ll * 256 + mm + 1])
            + t * u * longint'(field_tbl[(ll + 1) * 256 + mm + 1]);
        acc = (acc + (64'sd1 <<< 31)) >>> 32;
        res.field = acc[FW-1:0];
        return res;
    endfunction

    // update the local state for one accepted transaction and queue its result
    function automatic void apply_item(logic [1:0] kind, logic [13:0] idx,
                                       logic signed [23:0] lv, logic signed [15:0] r,
                                       logic signed [16:0] z);
        t_result res;
        res = '0;
        case (kind)
            REQ_LOAD_RADIAL: begin
                if (idx < RPTS) radial_pts[idx] = lv[14:0];
            end
            REQ_LOAD_AXIAL: begin
                if (idx < APTS) axial_pts[idx] = lv[15:0];
            end
            REQ_LOAD_MAP: begin
                field_tbl[idx] = lv;
                field_set[idx] = 1'b1;
            end
            default: res = interp_field(r, z);
        endcase
        pending_results.push_back(res);
    endfunction

    // ---------------------------------------------------------------- sender
    task automatic send_item(logic [1:0] kind, logic [13:0] idx, logic signed [23:0] lv,
                             logic signed [15:0] r, logic signed [16:0] z);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_req_type = kind;
        i_table_index = idx;
        i_load_value = lv;
        i_radius = r;
        i_axial_position = z;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        apply_item(kind, idx, lv, r, z);
    endtask

    task automatic load_map(int unsigned idx);
        send_item(REQ_LOAD_MAP, idx, $urandom, $urandom, $urandom);
    endtask

    // query, first loading any corner of its cell that was never written
    task automatic send_query(logic signed [15:0] r, logic signed [16:0] z);
        bit ok;
        int ll, mm;
        locate_cell(r, z, ok, ll, mm);
        if (ok) begin
            for (int dr = 0; dr < 2; dr++)
                for (int da = 0; da < 2; da++)
                    if (!field_set[(ll + dr) * 256 + mm + da])
                        load_map((ll + dr) * 256 + mm + da);
        end
        send_item(REQ_QUERY, $urandom, $urandom, r, z);
    endtask

    task automatic random_query();
        logic signed [15:0] r;
        logic signed [16:0] z;
        r = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, reg_rlimit + 2));
        z = ($urandom_range(0, 9) == 0) ? 17'($urandom)
                                        : 17'($urandom_range(0, reg_alimit + 2));
        if ($urandom_range(0, 1)) z = -z;
        send_query(r, z);
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_RADIAL_COUNT: reg_rcount = val[6:0];
            CFG_AXIAL_COUNT:  reg_acount = val[8:0];
            CFG_RADIAL_LIMIT: reg_rlimit = val[14:0];
            default:          reg_alimit = val[15:0];
        endcase
    endtask

    task automatic set_regs(int unsigned rc, int unsigned ac, int unsigned rl,
                            int unsigned al);
        drain();
        write_reg(CFG_RADIAL_COUNT, rc);
        write_reg(CFG_AXIAL_COUNT, ac);
        write_reg(CFG_RADIAL_LIMIT, rl);
        write_reg(CFG_AXIAL_LIMIT, al);
    endtask

    // ---------------------------------------------------------------- receiver
    initial begin
        int unsigned phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_cycles != 0) begin
                hold_cycles--;
                i_ready = 1'b0;
            end else begin
                case ((phase / 97) % 3)
                    0: i_ready = 1'b1;
                    1: i_ready = ($urandom_range(0, 1) == 1);
                    default: i_ready = ((phase % 5) == 0);
                endcase
            end
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: field %0d status %0d",
                             o_field_axial, o_status);
            end else begin
                want = pending_results.pop_front();
                if (want.field !== o_field_axial || want.status !== o_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected field %0d status %0d, got %0d %0d",
                                 want.field, want.status, o_field_axial, o_status);
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests
    task automatic test_grid_load();
        for (int i = 0; i < RPTS; i++) send_item(REQ_LOAD_RADIAL, i, i * 240, 0, 0);
        for (int i = 0; i < APTS; i++)
            send_item(REQ_LOAD_AXIAL, i, (i == 11) ? 1000 : i * 100, 0, 0);
        // out-of-range grid indexes are dropped
        send_item(REQ_LOAD_RADIAL, RPTS, -1, 0, 0);
        send_item(REQ_LOAD_RADIAL, 14'h3FFF, 24'h7FFFFF, 0, 0);
        send_item(REQ_LOAD_AXIAL, APTS, -1, 0, 0);
        send_item(REQ_LOAD_AXIAL, 14'h3FFF, 24'h800000, 0, 0);
    endtask

    task automatic test_directed();
        send_item(REQ_LOAD_MAP, 0, 24'sh7FFFFF, 0, 0);
        send_item(REQ_LOAD_MAP, 1, -24'sh800000, 0, 0);
        send_item(REQ_LOAD_MAP, 256, -24'sh800000, 0, 0);
        send_item(REQ_LOAD_MAP, 257, 24'sh7FFFFF, 0, 0);
        send_item(REQ_LOAD_MAP, 14'h3FFF, 24'sh123456, 0, 0);
        send_query(0, 0);
        send_query(120, 50);
        send_query(-1, 0);
        send_query(-16'sd32768, 0);
        send_query(16'sd32767, 0);
        send_query(15360, 25600);
        send_query(15361, 0);
        send_query(0, -25600);
        send_query(0, 25601);
        send_query(0, -25601);
        send_query(0, 17'sd65535);
        send_query(0, 17'sh10000);
        send_query(480, -1000);
        send_query(500, 1050);
        send_query(15200, 25550);
    endtask

    task automatic test_settings();
        set_regs(0, 0, 0, 0);
        repeat (10) random_query();
        set_regs(1, 1, 32767, 65535);
        repeat (30) random_query();
        set_regs(127, 511, 32767, 65535);
        repeat (30) random_query();
        set_regs(2, 2, 1000, 500);
        repeat (30) random_query();
        set_regs(8, 20, 15360, 25600);
        repeat (30) random_query();
    endtask

    task automatic test_random();
        set_regs($urandom_range(2, 16), $urandom_range(2, 32), $urandom_range(0, 32767),
                 $urandom);
        for (int n = 0; n < 120; n++) begin
            int unsigned pick;
            pick = $urandom_range(0, 99);
            if (n % 40 == 39)
                set_regs($urandom_range(0, 127), $urandom_range(0, 48),
                         $urandom_range(0, 32767), $urandom);
            if (pick < 60) random_query();
            else if (pick < 80) load_map($urandom_range(0, 16383));
            else if (pick < 90)
                send_item(REQ_LOAD_RADIAL, ($urandom_range(0, 7) == 0) ? $urandom
                          : $urandom_range(0, RPTS - 1), $urandom, $urandom, $urandom);
            else
                send_item(REQ_LOAD_AXIAL, ($urandom_range(0, 7) == 0) ? $urandom
                          : $urandom_range(0, APTS - 1), $urandom, $urandom, $urandom);
        end
    endtask

    // hold the result side off so the block fills and stalls its input
    task automatic test_backpressure();
        set_regs(4, 8, 32767, 65535);
        hold_cycles = 400;
        repeat (40) random_query();
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_grid_load();
        test_directed();
        test_settings();
        test_random();
        test_backpressure();
        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("field_map_bilinear_interp regression: pass");
        else
            $display("field_map_bilinear_interp regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("field_map_bilinear_interp regression: fail");
        $finish;
    end
endmodule
